@@ rtl/text_mode_terminal_writer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Text-mode terminal writer: assertion macros
// Shared assertion forms for the modules of the terminal writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH

// Property checked outside reset only.
`define TMTW_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Property checked at every clock edge, reset included.
`define TMTW_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/tmtw_pkg.sv @@
// ----------------------------------------------------------------------------
// Terminal writer package
// Screen geometry, character codes, cursor status type and cell addressing.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Field and storage widths.
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int PHASE_W    = $clog2(TAB_STOP);
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // Item kinds.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Cursor status handed from the cursor unit to the top level.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  nxt_row;
    logic [COL_W-1:0]  nxt_col;
    logic              scroll;
    logic              store;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] blank_addr;
  } cursor_t;

  // Rows live in a ring: the logical row is offset by the physical top row.
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [ROW_W-1:0] row,
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] top
  );
    logic [ROW_W:0]    sum;
    logic [ADDR_W-1:0] base;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    base = ADDR_W'(sum) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

@@ rtl/text_mode_terminal_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text-mode terminal writer
// Character-cell screen of 80 by 25 cells with cursor, scrolling and reads.
// ----------------------------------------------------------------------------
// A write item is done at once; a read item waits in a read state for the
// cell memory's registered read data. Each gives one result item. A write
// item that scrolls the screen turns the row ring by one and then blanks
// the new bottom row, one cell a cycle, taking no item until its 80 cells
// are blank. After reset the block clears all 2000 cells, one a cycle, and
// takes no item until done; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_mode_terminal_writer_top_defines.svh"

module text_mode_terminal_writer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration: text attribute byte.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tmtw_pkg::ATTR_W-1:0]     cfg_data_i,
  // Input items.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] char_byte, [12:8] read_row, [19:13] read_column, [23:20] zero
  input  wire logic [tmtw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  wire logic                            s_axis_tuser,
  // Result items.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] cell_char, [15:8] cell_attr, [20:16] cursor_row_out,
  // [27:21] cursor_column_out, [28] scrolled, [31:29] zero
  output logic      [tmtw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int ROW_W  = tmtw_pkg::ROW_W;
  localparam int COL_W  = tmtw_pkg::COL_W;
  localparam int ADDR_W = tmtw_pkg::ADDR_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_BLANK = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [ADDR_W-1:0]               sweep_q, sweep_d;
  logic [ADDR_W-1:0]               sweep_last_q, sweep_last_d;
  logic [tmtw_pkg::ATTR_W-1:0]     fill_attr_q, fill_attr_d;
  logic [tmtw_pkg::ATTR_W-1:0]     text_attr_q;
  logic                            rd_ok_q, rd_ok_d;
  logic                            out_valid_q, out_valid_d;
  logic [tmtw_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                            in_fire;
  logic                            in_op;
  logic [tmtw_pkg::CHAR_W-1:0]     in_char;
  logic [ROW_W-1:0]                in_row;
  logic [COL_W-1:0]                in_col;
  logic                            wr_step;
  logic                            rd_step;
  tmtw_pkg::cursor_t               curs;

  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [tmtw_pkg::CELL_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]               ram_raddr;
  logic [tmtw_pkg::CELL_W-1:0]     ram_rdata;

  // Unpack the input item.
  assign in_op   = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[12:8];
  assign in_col  = s_axis_tdata[19:13];

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wr_step       = in_fire && (in_op == tmtw_pkg::OP_WRITE);
  assign rd_step       = in_fire && (in_op == tmtw_pkg::OP_READ);

  // Attribute register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= tmtw_pkg::RESET_ATTR;
    end else if (cfg_valid_i) begin
      text_attr_q <= cfg_data_i;
    end
  end

  // Cursor and row ring.
  tmtw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (wr_step),
    .char_i (in_char),
    .curs_o (curs)
  );

  // Memory write port: the sweep owns it while clearing or blanking.
  always_comb begin
    if ((state_q == ST_CLEAR) || (state_q == ST_BLANK)) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = {fill_attr_q, tmtw_pkg::CHAR_SPACE};
    end else begin
      ram_we    = wr_step && curs.store;
      ram_waddr = curs.cell_addr;
      ram_wdata = {text_attr_q, in_char};
    end
  end

  assign ram_raddr = tmtw_pkg::cell_addr(in_row, in_col, curs.top_row);

  tmtw_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_step),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: clearing pass, item handling and row blanking.
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    sweep_last_d = sweep_last_q;
    fill_attr_d  = fill_attr_q;
    rd_ok_d      = rd_ok_q;
    unique case (state_q)
      ST_CLEAR, ST_BLANK: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == sweep_last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_step) begin
          state_d = ST_READ;
          rd_ok_d = (in_row < ROW_W'(tmtw_pkg::ROWS))
                 && (in_col < COL_W'(tmtw_pkg::COLUMNS));
        end else if (wr_step && curs.scroll) begin
          state_d      = ST_BLANK;
          sweep_d      = curs.blank_addr;
          sweep_last_d = curs.blank_addr + ADDR_W'(tmtw_pkg::COLUMNS - 1);
          fill_attr_d  = text_attr_q;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register: loaded on a write item, or in the cycle after a read item.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (wr_step) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, curs.scroll, curs.nxt_col, curs.nxt_row,
                     8'h00, 8'h00};
    end else if (state_q == ST_READ) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, 1'b0, curs.col, curs.row,
                     rd_ok_q ? ram_rdata : {tmtw_pkg::CELL_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_q      <= '0;
      sweep_last_q <= ADDR_W'(tmtw_pkg::CELL_COUNT - 1);
      fill_attr_q  <= tmtw_pkg::RESET_ATTR;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      sweep_last_q <= sweep_last_d;
      fill_attr_q  <= fill_attr_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `TMTW_ASSERT_RST(a_busy_no_take, clk_i, rst_ni, (state_q != ST_IDLE) |-> !s_axis_tready, "item taken while busy")
  `TMTW_ASSERT_RST(a_read_seq, clk_i, rst_ni, rd_step |=> (state_q == ST_READ), "read item did not wait for memory")
  `TMTW_ASSERT_RST(a_read_result, clk_i, rst_ni, (state_q == ST_READ) |=> m_axis_tvalid, "read item gave no result")
  `TMTW_ASSERT_RST(a_blank_bound, clk_i, rst_ni, (state_q == ST_BLANK) |-> (sweep_q <= sweep_last_q), "row blanking ran past its row")

endmodule

`default_nettype wire

@@ rtl/tmtw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// Terminal writer cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtw_cell_ram (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [tmtw_pkg::ADDR_W-1:0] waddr_i,
  input  wire logic [tmtw_pkg::CELL_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [tmtw_pkg::ADDR_W-1:0] raddr_i,
  output logic      [tmtw_pkg::CELL_W-1:0] rdata_o
);

  logic [tmtw_pkg::CELL_W-1:0] mem_q [tmtw_pkg::CELL_COUNT];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmtw_cursor.sv @@
// ----------------------------------------------------------------------------
// Terminal writer cursor unit
// Holds the cursor, tab phase and ring top row; decodes write characters.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_mode_terminal_writer_top_defines.svh"

module tmtw_cursor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [tmtw_pkg::CHAR_W-1:0] char_i,
  output tmtw_pkg::cursor_t                curs_o
);

  localparam int ROW_W   = tmtw_pkg::ROW_W;
  localparam int COL_W   = tmtw_pkg::COL_W;
  localparam int PHASE_W = tmtw_pkg::PHASE_W;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   top_q, top_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [COL_W:0]     tab_sum;
  logic               adv;
  logic               scroll;
  logic               store;

  // Column reached by a tab, one bit wider to see the line end.
  assign tab_sum = {1'b0, col_q} + (COL_W+1)'(tmtw_pkg::TAB_STOP)
                 - (COL_W+1)'(phase_q);

  // Character decode and row advance.
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    row_d   = row_q;
    top_d   = top_q;
    adv     = 1'b0;
    scroll  = 1'b0;
    store   = 1'b0;
    unique case (char_i)
      tmtw_pkg::CHAR_BS: begin
        if (col_q != '0) begin
          col_d   = col_q - 1'b1;
          phase_d = (phase_q == '0) ? PHASE_W'(tmtw_pkg::TAB_STOP - 1)
                                    : phase_q - 1'b1;
        end
      end
      tmtw_pkg::CHAR_TAB: begin
        phase_d = '0;
        if (tab_sum >= (COL_W+1)'(tmtw_pkg::COLUMNS)) begin
          col_d = '0;
          adv   = 1'b1;
        end else begin
          col_d = tab_sum[COL_W-1:0];
        end
      end
      tmtw_pkg::CHAR_CR: begin
        col_d   = '0;
        phase_d = '0;
      end
      tmtw_pkg::CHAR_LF: begin
        col_d   = '0;
        phase_d = '0;
        adv     = 1'b1;
      end
      default: begin
        if (char_i >= tmtw_pkg::CHAR_SPACE) begin
          store = 1'b1;
          if (col_q == COL_W'(tmtw_pkg::COLUMNS - 1)) begin
            col_d   = '0;
            phase_d = '0;
            adv     = 1'b1;
          end else begin
            col_d   = col_q + 1'b1;
            phase_d = (phase_q == PHASE_W'(tmtw_pkg::TAB_STOP - 1)) ? '0
                                                                     : phase_q + 1'b1;
          end
        end
      end
    endcase
    // On the last row the ring turns instead: the old top becomes the bottom.
    if (adv) begin
      if (row_q == ROW_W'(tmtw_pkg::ROWS - 1)) begin
        scroll = 1'b1;
        top_d  = (top_q == ROW_W'(tmtw_pkg::ROWS - 1)) ? '0 : top_q + 1'b1;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
  end

  // Cursor registers move only on an accepted write item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      phase_q <= '0;
    end else if (step_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      phase_q <= phase_d;
    end
  end

  // Status towards the top level.
  always_comb begin
    curs_o.row        = row_q;
    curs_o.col        = col_q;
    curs_o.top_row    = top_q;
    curs_o.nxt_row    = row_d;
    curs_o.nxt_col    = col_d;
    curs_o.scroll     = scroll;
    curs_o.store      = store;
    curs_o.cell_addr  = tmtw_pkg::cell_addr(row_q, col_q, top_q);
    curs_o.blank_addr = tmtw_pkg::cell_addr('0, '0, top_q);
  end

  `TMTW_ASSERT_RST(a_row_range, clk_i, rst_ni, row_q < ROW_W'(tmtw_pkg::ROWS), "cursor row off screen")
  `TMTW_ASSERT_RST(a_col_range, clk_i, rst_ni, col_q < COL_W'(tmtw_pkg::COLUMNS), "cursor column off screen")
  `TMTW_ASSERT_RST(a_top_range, clk_i, rst_ni, top_q < ROW_W'(tmtw_pkg::ROWS), "ring top row out of range")
  `TMTW_ASSERT_RST(a_tab_phase, clk_i, rst_ni, (col_q % tmtw_pkg::TAB_STOP) == phase_q, "tab phase lost step")
  `TMTW_ASSERT_RST(a_scroll_row, clk_i, rst_ni, (step_i && scroll) |=> (row_q == ROW_W'(tmtw_pkg::ROWS - 1)), "scroll left the bottom row")

endmodule

`default_nettype wire
